// ----- rtl/core/stwe_pkg.sv -----
// ----------------------------------------------------------------------------
// stwe_pkg
// Shared types and constants of the signature triple word extractor.
// ----------------------------------------------------------------------------
package stwe_pkg;

    localparam int WINDOW_LEN = 24;
    localparam int MARK_LEN   = 12;
    localparam int WORD_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [WORD_W-1:0] SIG_RESET = 32'h3F80_0000;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SIG_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIG_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIG_THIRD  = 2'd2;

    // per-cell control
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // window control from the top level
    typedef struct packed {
        logic shift;
        logic restart;
    } win_ctrl_t;

    // window status towards the top level
    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] x_word;
        logic [WORD_W-1:0] y_word;
        logic [WORD_W-1:0] z_word;
    } win_stat_t;

endpackage

// ----- rtl/core/signature_triple_word_extractor_top.sv -----
// ----------------------------------------------------------------------------
// signature_triple_word_extractor_top
// Scans a byte stream for a twelve-byte marker and reports the three words
// that follow it.
// ----------------------------------------------------------------------------
// One byte word is taken per clock, back to back, unless the slave side
// stalls, through a chain of 24 byte cells. The byte that completes the
// window is registered in the cells and its result in the master side's single
// output register. The slave side stalls only when a pending match finds that
// output register still holding an earlier result that has not been taken.
// A restart flag in tuser clears the window and the offset count in the same
// cycle as it takes its byte. No clearing pass is needed after reset; the
// cells carry valid flags that reset clears at once. The offset count stops
// at its top value and reported offsets then stay put.
// ----------------------------------------------------------------------------
module signature_triple_word_extractor_top
#(
    parameter int POSITION_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] restart

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [31:0] match_offset, [63:32] x_word,
                                    // [95:64] y_word, [127:96] z_word

    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int OFF_W = (POSITION_BITS < 32) ? POSITION_BITS : 32;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] WIN_BACK =
        POSITION_BITS'(stwe_pkg::WINDOW_LEN - 1);

    // ---------------------------------------------------------------- config
    logic [31:0] sig_first_reg;
    logic [31:0] sig_second_reg;
    logic [31:0] sig_third_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_first_reg  <= stwe_pkg::SIG_RESET;
            sig_second_reg <= stwe_pkg::SIG_RESET;
            sig_third_reg  <= stwe_pkg::SIG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stwe_pkg::REG_SIG_FIRST:  sig_first_reg  <= cfg_wdata;
                stwe_pkg::REG_SIG_SECOND: sig_second_reg <= cfg_wdata;
                stwe_pkg::REG_SIG_THIRD:  sig_third_reg  <= cfg_wdata;
                default:                  ; // unknown index: ignore the write
            endcase
        end
    end

    // ---------------------------------------------------------------- window
    stwe_pkg::win_ctrl_t wctrl;
    stwe_pkg::win_stat_t wstat;
    logic                accept;

    assign wctrl.shift   = accept;
    assign wctrl.restart = s_tuser;

    stwe_window u_window
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (wctrl),
        .in_byte    (s_tdata),
        .sig_first  (sig_first_reg),
        .sig_second (sig_second_reg),
        .sig_third  (sig_third_reg),
        .stat       (wstat)
    );

    // ------------------------------------------------- position and pending
    // pend_reg marks that the window has just taken a byte whose compare is
    // still to be looked at; cur_reg holds that byte's stream offset.
    logic                     pend_reg;
    logic                     pend_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] cur_reg;
    logic [POSITION_BITS-1:0] cur_next;
    logic [POSITION_BITS-1:0] cur_in;
    logic [POSITION_BITS-1:0] off_full;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic [127:0] out_data_reg;
    logic         out_free;
    logic         pend_hit;
    logic         load;

    assign out_free = !out_valid_reg || m_tready;
    assign pend_hit = pend_reg && wstat.hit;
    assign load     = pend_hit && out_free;
    // a pending miss is simply dropped, so only a blocked hit holds the input
    assign s_tready = !pend_hit || out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cur_in   = s_tuser ? '0 : pos_reg;
        pos_next = pos_reg;
        cur_next = cur_reg;
        if (accept)
        begin
            // saturate the offset count at its top value
            pos_next = (cur_in == POS_MAX) ? cur_in : cur_in + POSITION_BITS'(1);
            cur_next = cur_in;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (pend_hit && !out_free)
        begin
            pend_next = 1'b1;
        end
        else
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // offset of the window's first byte; only the low word leaves the block
    assign off_full = cur_reg - WIN_BACK;

    // ---------------------------------------------------------------- output
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= {wstat.z_word, wstat.y_word, wstat.x_word,
                             32'(off_full[OFF_W-1:0])};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- rtl/core/stwe_cell.sv -----
// ----------------------------------------------------------------------------
// stwe_cell
// One byte cell of the window chain: a byte and its valid flag.
// ----------------------------------------------------------------------------
module stwe_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  stwe_pkg::cell_ctrl_t       ctrl,
    input  logic [stwe_pkg::BYTE_W-1:0] in_byte,
    input  logic                       in_valid,
    output logic [stwe_pkg::BYTE_W-1:0] byte_q,
    output logic                       valid_q
);

    logic [stwe_pkg::BYTE_W-1:0] byte_reg;
    logic [stwe_pkg::BYTE_W-1:0] byte_next;
    logic                        valid_reg;
    logic                        valid_next;

    // drop the neighbour's word on a restart
    always_comb
    begin
        byte_next  = ctrl.clear ? '0 : in_byte;
        valid_next = ctrl.clear ? 1'b0 : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_q  = byte_reg;
    assign valid_q = valid_reg;

endmodule

// ----- rtl/core/stwe_window.sv -----
// ----------------------------------------------------------------------------
// stwe_window
// Chain of byte cells forming the sliding window, with the marker compare.
// ----------------------------------------------------------------------------
module stwe_window
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  stwe_pkg::win_ctrl_t         ctrl,
    input  logic [stwe_pkg::BYTE_W-1:0] in_byte,
    input  logic [stwe_pkg::WORD_W-1:0] sig_first,
    input  logic [stwe_pkg::WORD_W-1:0] sig_second,
    input  logic [stwe_pkg::WORD_W-1:0] sig_third,
    output stwe_pkg::win_stat_t         stat
);

    localparam int LAST = stwe_pkg::WINDOW_LEN - 1;

    logic [stwe_pkg::BYTE_W-1:0] byte_q  [stwe_pkg::WINDOW_LEN];
    logic                        valid_q [stwe_pkg::WINDOW_LEN];

    genvar i;
    generate
        for (i = 0; i < stwe_pkg::WINDOW_LEN; i++)
        begin : g_cell
            stwe_pkg::cell_ctrl_t cctrl;
            if (i == LAST)
            begin : g_head
                // newest byte enters here and is always valid
                assign cctrl.shift = ctrl.shift;
                assign cctrl.clear = 1'b0;
                stwe_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (cctrl),
                    .in_byte  (in_byte),
                    .in_valid (1'b1),
                    .byte_q   (byte_q[i]),
                    .valid_q  (valid_q[i])
                );
            end
            else
            begin : g_body
                assign cctrl.shift = ctrl.shift;
                assign cctrl.clear = ctrl.restart;
                stwe_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (cctrl),
                    .in_byte  (byte_q[i+1]),
                    .in_valid (valid_q[i+1]),
                    .byte_q   (byte_q[i]),
                    .valid_q  (valid_q[i])
                );
            end
        end
    endgenerate

    logic [stwe_pkg::WORD_W-1:0] w0;
    logic [stwe_pkg::WORD_W-1:0] w1;
    logic [stwe_pkg::WORD_W-1:0] w2;

    assign w0 = {byte_q[0], byte_q[1], byte_q[2], byte_q[3]};
    assign w1 = {byte_q[4], byte_q[5], byte_q[6], byte_q[7]};
    assign w2 = {byte_q[8], byte_q[9], byte_q[10], byte_q[11]};

    // the oldest cell is valid only once the whole window is filled
    assign stat.hit = valid_q[0] && (w0 == sig_first) && (w1 == sig_second)
                      && (w2 == sig_third);
    assign stat.x_word = {byte_q[12], byte_q[13], byte_q[14], byte_q[15]};
    assign stat.y_word = {byte_q[16], byte_q[17], byte_q[18], byte_q[19]};
    assign stat.z_word = {byte_q[20], byte_q[21], byte_q[22], byte_q[23]};

endmodule

// ----- tb/sv/tb_signature_triple_word_extractor_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signature_triple_word_extractor_top
// Self-checking bench for the twelve-byte marker scanner.
// ----------------------------------------------------------------------------
// Byte words go in on the slave side and each one is run through a local
// copy of the scanner: a 24-byte window, a fill count and a saturating
// offset count. Every predicted match is queued, and each word taken on the
// master side is compared field by field with the oldest queued match.
// A short table of bytes opens the run, then marker-rich random traffic is
// sent under several signature settings and three idling patterns.
// ----------------------------------------------------------------------------
module tb_signature_triple_word_extractor_top;

    // narrow offset count, so that the low-bit path of the offset is used
    localparam int POS_BITS    = 16;
    localparam int CYCLE_LIMIT = 900_000;
    localparam int DRAIN_LIMIT = 5_000;
    localparam int TAIL_CYCLES = 8;

    // index with no register behind it; writes to it must be dropped
    localparam logic [stwe_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // one result word, laid out exactly as m_tdata (offset in the low bits)
    typedef struct packed {
        logic [stwe_pkg::WORD_W-1:0] z_word;
        logic [stwe_pkg::WORD_W-1:0] y_word;
        logic [stwe_pkg::WORD_W-1:0] x_word;
        logic [stwe_pkg::WORD_W-1:0] match_offset;
    } hit_t;

    localparam hit_t NO_HIT = '0;

    // how a table row is checked: by prediction, as silent, or as typed in
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_QUIET,
        ROW_GIVEN
    } row_outcome_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         restart;
        row_outcome_t outcome;
        hit_t         hit;
    } stim_row_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [7:0]    s_tdata   = 8'h00;
    logic          s_tuser   = 1'b0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [127:0]  m_tdata;
    logic          cfg_we    = 1'b0;
    logic [1:0]    cfg_index = 2'd0;
    logic [31:0]   cfg_wdata = 32'h0;

    // scanner copy: signature, window, fill and offset count
    logic [stwe_pkg::WORD_W-1:0] marker_word [3];
    logic [stwe_pkg::BYTE_W-1:0] win_bytes [stwe_pkg::WINDOW_LEN];
    int unsigned                 win_fill;
    logic [POS_BITS-1:0]         byte_pos;

    hit_t        expected_hits [$];
    stim_row_t   directed_rows [25];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;

    signature_triple_word_extractor_top #(
        .POSITION_BITS (POS_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Safety net: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %h expected %h (cycle %0d)",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Advance the scanner copy by one byte; return 1 with the match found.
    function automatic bit scan_byte(input logic [7:0] b, input logic restart,
                                     output hit_t h);
        logic [stwe_pkg::WORD_W-1:0] w [6];
        logic [POS_BITS-1:0]         cur;
        longint unsigned             off;
        int                          i;
        h = NO_HIT;
        // restart clears everything before the byte is taken as offset 0
        if (restart)
        begin
            for (i = 0; i < stwe_pkg::WINDOW_LEN; i++)
                win_bytes[i] = '0;
            win_fill = 0;
            byte_pos = '0;
        end
        for (i = 0; i < stwe_pkg::WINDOW_LEN - 1; i++)
            win_bytes[i] = win_bytes[i + 1];
        win_bytes[stwe_pkg::WINDOW_LEN - 1] = b;
        if (win_fill < stwe_pkg::WINDOW_LEN)
            win_fill++;
        cur = byte_pos;
        // hold the count at its top value once reached
        if (byte_pos != '1)
            byte_pos++;
        for (i = 0; i < 6; i++)
            w[i] = {win_bytes[4*i], win_bytes[4*i+1], win_bytes[4*i+2],
                    win_bytes[4*i+3]};
        if (win_fill == stwe_pkg::WINDOW_LEN && w[0] == marker_word[0] &&
            w[1] == marker_word[1] && w[2] == marker_word[2])
        begin
            off = 64'(cur) - 64'(stwe_pkg::WINDOW_LEN - 1);
            h.match_offset = off[31:0];
            h.x_word       = w[3];
            h.y_word       = w[4];
            h.z_word       = w[5];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Present one byte word, idling first at the current sender rate, and
    // queue what it should produce once it is taken.
    task automatic push_byte(input logic [7:0] b, input logic restart,
                             input row_outcome_t outcome, input hit_t typed);
        hit_t h;
        bit   found;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 1'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= restart;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        found = scan_byte(b, restart, h);
        if (outcome == ROW_GIVEN)
            expected_hits.insert(expected_hits.size(), typed);
        else if (outcome == ROW_PREDICT && found)
            expected_hits.insert(expected_hits.size(), h);
    endtask

    // Send the current twelve-byte marker, optionally with one byte spoilt.
    task automatic send_marker(input logic restart_first, input bit spoil);
        logic [7:0] mb [12];
        int         i;
        int         bad;
        for (i = 0; i < 12; i++)
            mb[i] = marker_word[i / 4][8 * (3 - i % 4) +: 8];
        if (spoil)
        begin
            bad = $urandom_range(11);
            mb[bad] = mb[bad] ^ 8'($urandom_range(255, 1));
        end
        for (i = 0; i < 12; i++)
            push_byte(mb[i], restart_first && (i == 0), ROW_PREDICT, NO_HIT);
    endtask

    // Mostly well-formed markers with random payload, plus repeats of the
    // first word (overlapping matches when the words agree), restarts,
    // broken markers and plain noise.
    task automatic stream_random(input int n_bytes);
        int sent;
        int pick;
        int extra;
        int k;
        int i;
        sent = 0;
        while (sent < n_bytes)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                send_marker($urandom_range(9) == 0, $urandom_range(6) == 0);
                sent += 12;
                extra = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
                for (k = 0; k < extra; k++)
                    for (i = 0; i < 4; i++)
                        push_byte(marker_word[0][8 * (3 - i) +: 8], 1'b0,
                                  ROW_PREDICT, NO_HIT);
                sent += 4 * extra;
                k = $urandom_range(16);
                for (i = 0; i < k; i++)
                    push_byte(8'($urandom), 1'b0, ROW_PREDICT, NO_HIT);
                sent += k;
            end
            else if (pick < 64)
            begin
                push_byte(8'($urandom), 1'b1, ROW_PREDICT, NO_HIT);
                sent++;
            end
            else
            begin
                k = $urandom_range(10, 1);
                for (i = 0; i < k; i++)
                    push_byte(8'($urandom), 1'b0, ROW_PREDICT, NO_HIT);
                sent += k;
            end
        end
    endtask

    // Drop valid, wait for every queued match, then let the pipe run dry.
    task automatic settle_stream();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (expected_hits.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_hits.size() != 0)
        begin
            report_mismatch("results never delivered, count",
                            32'(expected_hits.size()), 32'd0);
            expected_hits.delete();
        end
        repeat (TAIL_CYCLES)
            @(posedge clk);
    endtask

    // Write all three signature words, and the unused index if asked.
    task automatic program_signature(input logic [31:0] w0, input logic [31:0] w1,
                                     input logic [31:0] w2, input bit poke_spare);
        logic [stwe_pkg::CFG_IDX_W-1:0] idx [4];
        logic [31:0]                    val [4];
        int                             n;
        int                             i;
        idx = '{stwe_pkg::REG_SIG_FIRST, stwe_pkg::REG_SIG_SECOND,
                stwe_pkg::REG_SIG_THIRD, REG_SPARE};
        val = '{w0, w1, w2, $urandom};
        n   = poke_spare ? 4 : 3;
        for (i = 0; i < n; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
            case (idx[i])
                stwe_pkg::REG_SIG_FIRST:  marker_word[0] = val[i];
                stwe_pkg::REG_SIG_SECOND: marker_word[1] = val[i];
                stwe_pkg::REG_SIG_THIRD:  marker_word[2] = val[i];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // Result side: check the word taken at this edge, then pick the next
    // ready level at the current receiver rate.
    always @(posedge clk)
    begin
        hit_t got;
        hit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_hits.size() == 0)
                report_mismatch("result with none expected, offset",
                                got.match_offset, 32'd0);
            else
            begin
                want = expected_hits.pop_front();
                if (got.match_offset != want.match_offset)
                    report_mismatch("match_offset", got.match_offset,
                                    want.match_offset);
                if (got.x_word != want.x_word)
                    report_mismatch("x_word", got.x_word, want.x_word);
                if (got.y_word != want.y_word)
                    report_mismatch("y_word", got.y_word, want.y_word);
                if (got.z_word != want.z_word)
                    report_mismatch("z_word", got.z_word, want.z_word);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        int i;
        logic [31:0] w;

        // scanner copy starts in its reset state
        for (i = 0; i < 3; i++)
            marker_word[i] = stwe_pkg::SIG_RESET;
        for (i = 0; i < stwe_pkg::WINDOW_LEN; i++)
            win_bytes[i] = '0;
        win_fill = 0;
        byte_pos = '0;

        // Opening table: a stray byte, then a restart mid-stream that must
        // clear it, the default marker and a payload of extreme bytes. Only
        // the byte that fills the window gives a result, at offset 0.
        directed_rows = '{
            '{8'hFF, 1'b1, ROW_QUIET, NO_HIT},
            '{8'h3F, 1'b1, ROW_QUIET, NO_HIT},
            '{8'h80, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h00, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h00, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h3F, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h80, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h00, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h00, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h3F, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h80, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h00, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h00, 1'b0, ROW_QUIET, NO_HIT},
            '{8'hFF, 1'b0, ROW_QUIET, NO_HIT},
            '{8'hFF, 1'b0, ROW_QUIET, NO_HIT},
            '{8'hFF, 1'b0, ROW_QUIET, NO_HIT},
            '{8'hFF, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h00, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h00, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h00, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h00, 1'b0, ROW_QUIET, NO_HIT},
            '{8'hA5, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h5A, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h01, 1'b0, ROW_QUIET, NO_HIT},
            '{8'h80, 1'b0, ROW_GIVEN,
              '{z_word: 32'hA55A_0180, y_word: 32'h0000_0000,
                x_word: 32'hFFFF_FFFF, match_offset: 32'd0}}
        };

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 28;
        recv_idle_pct <= 86;
        for (i = 0; i < 25; i++)
            push_byte(directed_rows[i].data, directed_rows[i].restart,
                      directed_rows[i].outcome, directed_rows[i].hit);
        stream_random(450);

        // all-zero marker: cleared window bytes must not count as a match;
        // also poke the unused index, which must change nothing
        settle_stream();
        program_signature(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        stream_random(300);

        // swap the idling: sender heavy, receiver light
        send_idle_pct = 86;
        recv_idle_pct <= 28;
        settle_stream();
        program_signature(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        stream_random(350);

        settle_stream();
        program_signature($urandom, $urandom, $urandom, 1'b1);
        stream_random(300);

        // no idling on either side; equal words give overlapping matches
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        settle_stream();
        w = $urandom;
        program_signature(w, w, w, 1'b0);
        stream_random(500);

        settle_stream();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/stwe_pkg.sv
rtl/core/stwe_cell.sv
rtl/core/stwe_window.sv
rtl/core/signature_triple_word_extractor_top.sv
tb/sv/tb_signature_triple_word_extractor_top.sv
